FILE: src/wma_pkg.sv
// ============================================================================
// wma_pkg
// Shared widths, constants and controller/datapath handshake types for the
// window moving average block.
// ============================================================================
package wma_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned SUM_BITS     = SAMPLE_BITS + 8;
  localparam int unsigned SUM_EXT      = SUM_BITS - SAMPLE_BITS;
  localparam int unsigned WINDOW_MAX   = 256;
  localparam int unsigned PTR_BITS     = $clog2(WINDOW_MAX);
  localparam int unsigned WIDTH_BITS   = PTR_BITS + 1;
  localparam int unsigned DIV_CNT_BITS = $clog2(SUM_BITS);

  localparam logic [WIDTH_BITS-1:0]   WIDTH_RESET = WIDTH_BITS'(4);
  localparam logic [WIDTH_BITS-1:0]   WIDTH_MIN   = WIDTH_BITS'(1);
  localparam logic [WIDTH_BITS-1:0]   WIDTH_TOP   = WIDTH_BITS'(WINDOW_MAX);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST    = DIV_CNT_BITS'(SUM_BITS - 1);

  // Saturation limits of the average, seen as magnitudes of the quotient.
  localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SUM_BITS-1:0] NEG_LIMIT = SUM_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [SAMPLE_BITS-1:0] AVG_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] AVG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic accept;    // item taken this cycle
    logic update;    // old sample is on the RAM read port
    logic div_step;  // one quotient bit
    logic finish;    // sign fix and saturation of the quotient
    logic sel_held;  // present the held first average
  } wma_cmd_t;

  typedef struct packed {
    logic fill;      // item only adds to the window
    logic reach;     // item completes the first window
    logic pair;      // item gives the held average and a new one
    logic div_last;  // final quotient bit this cycle
  } wma_status_t;

endpackage

FILE: src/wma_if.sv
// ============================================================================
// wma_if
// Valid/ready channels of the window moving average: sample input, average
// output and width configuration.
// ============================================================================
interface wma_sample_if;
  import wma_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   start_of_table;

  modport source (output valid, output sample, output start_of_table, input ready);
  modport sink   (input valid, input sample, input start_of_table, output ready);
endinterface

interface wma_average_if;
  import wma_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] average;
  logic                   last_of_run;

  modport source (output valid, output average, output last_of_run, input ready);
  modport sink   (input valid, input average, input last_of_run, output ready);
endinterface

interface wma_cfg_if;
  import wma_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/wma_ram.sv
// ============================================================================
// wma_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
// ============================================================================
module wma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/wma_datapath.sv
// ============================================================================
// wma_datapath
// Width register, running sum, window store, serial divider and the result
// registers of the window moving average.
// ============================================================================
module wma_datapath import wma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wma_cmd_t               cmd_i,
  output wma_status_t            status_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   start_i,
  input  logic                   cfg_we_i,
  input  logic [WIDTH_BITS-1:0]  cfg_data_i,
  output logic [SAMPLE_BITS-1:0] average_o,
  output logic                   last_of_run_o
);

  logic [WIDTH_BITS-1:0]   width_q;
  logic [WIDTH_BITS-1:0]   w_eff;
  logic [WIDTH_BITS-1:0]   w_q;
  logic [SUM_BITS-1:0]     sum_q, sum_d;
  logic [WIDTH_BITS-1:0]   count_q;
  logic [SAMPLE_BITS-1:0]  held_q;
  logic [SAMPLE_BITS-1:0]  avg_q;
  logic [PTR_BITS-1:0]     ptr_q;
  logic [SAMPLE_BITS-1:0]  sample_q;
  logic                    fill_q, reach_q, pair_q;
  logic [WIDTH_BITS-1:0]   count_eff;
  logic [PTR_BITS-1:0]     ptr_eff;
  logic [PTR_BITS-1:0]     old_addr;
  logic [SAMPLE_BITS-1:0]  old_sample;
  logic [SUM_BITS-1:0]     div_mag;
  logic [SUM_BITS-1:0]     quo_q;
  logic [WIDTH_BITS-1:0]   rem_q;
  logic [DIV_CNT_BITS-1:0] div_cnt_q;
  logic                    neg_q;
  logic [WIDTH_BITS:0]     trial;
  logic [WIDTH_BITS:0]     trial_diff;
  logic                    trial_ge;
  logic [SUM_BITS-1:0]     quo_neg;
  logic [SAMPLE_BITS-1:0]  result;

  // Width register, clamped into 1..WINDOW_MAX for use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      width_q <= cfg_data_i;
    end
  end

  always_comb begin
    priority if (width_q == '0) begin
      w_eff = WIDTH_MIN;
    end else if (width_q > WIDTH_TOP) begin
      w_eff = WIDTH_TOP;
    end else begin
      w_eff = width_q;
    end
  end

  // A start flag makes the item see a cleared table.
  assign count_eff = start_i ? '0 : count_q;
  assign ptr_eff   = start_i ? '0 : ptr_q;
  // Oldest sample of the window; a full-size window wraps onto the write slot.
  assign old_addr  = ptr_eff - w_eff[PTR_BITS-1:0];

  wma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (ptr_eff),
    .wdata_i (sample_i),
    .raddr_i (old_addr),
    .rdata_o (old_sample)
  );

  always_comb begin
    if (fill_q) begin
      sum_d = sum_q + {{SUM_EXT{sample_q[SAMPLE_BITS-1]}}, sample_q};
    end else begin
      sum_d = sum_q + {{SUM_EXT{sample_q[SAMPLE_BITS-1]}}, sample_q}
                    - {{SUM_EXT{old_sample[SAMPLE_BITS-1]}}, old_sample};
    end
  end

  assign div_mag = sum_d[SUM_BITS-1] ? (SUM_BITS'(0) - sum_d) : sum_d;

  // Table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      held_q  <= '0;
      ptr_q   <= '0;
      fill_q  <= 1'b0;
      reach_q <= 1'b0;
      pair_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (start_i) begin
          sum_q   <= '0;
          count_q <= '0;
          held_q  <= '0;
        end
        ptr_q   <= ptr_eff + PTR_BITS'(1);
        fill_q  <= count_eff < w_eff;
        reach_q <= (count_eff + WIDTH_BITS'(1)) == w_eff;
        pair_q  <= count_eff == w_eff;
      end
      if (cmd_i.update) begin
        sum_q   <= sum_d;
        count_q <= fill_q ? (count_q + WIDTH_BITS'(1)) : (w_q + WIDTH_BITS'(1));
      end
      if (cmd_i.finish && fill_q) begin
        held_q <= result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      w_q      <= w_eff;
    end
    if (cmd_i.finish && !fill_q) begin
      avg_q <= result;
    end
  end

  // Restoring divider on the magnitude of the sum, one quotient bit a cycle.
  assign trial      = {rem_q, quo_q[SUM_BITS-1]};
  assign trial_diff = trial - {1'b0, w_q};
  assign trial_ge   = trial >= {1'b0, w_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      quo_q     <= div_mag;
      rem_q     <= '0;
      neg_q     <= sum_d[SUM_BITS-1];
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q     <= {quo_q[SUM_BITS-2:0], trial_ge};
      rem_q     <= trial_ge ? trial_diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
      div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
    end
  end

  assign quo_neg = SUM_BITS'(0) - quo_q;

  always_comb begin
    if (neg_q) begin
      result = (quo_q > NEG_LIMIT) ? AVG_MIN : quo_neg[SAMPLE_BITS-1:0];
    end else begin
      result = (quo_q > POS_LIMIT) ? AVG_MAX : quo_q[SAMPLE_BITS-1:0];
    end
  end

  assign status_o.fill     = fill_q;
  assign status_o.reach    = reach_q;
  assign status_o.pair     = pair_q;
  assign status_o.div_last = div_cnt_q == DIV_LAST;

  assign average_o     = cmd_i.sel_held ? held_q : avg_q;
  assign last_of_run_o = !cmd_i.sel_held;

endmodule

FILE: src/wma_ctrl.sv
// ============================================================================
// wma_ctrl
// Sequencer of the window moving average: takes an item, runs the sum update
// and the serial divide, then hands out no, one or two results.
// ============================================================================
module wma_ctrl import wma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  wma_status_t status_i,
  output wma_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_UPDATE    = 6'b000010,
    ST_DIVIDE    = 6'b000100,
    ST_FINISH    = 6'b001000,
    ST_EMIT_HELD = 6'b010000,
    ST_EMIT_AVG  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        // A sample that only adds to an unfinished window needs no divide.
        if (status_i.fill && !status_i.reach) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        priority if (status_i.fill) begin
          state_d = ST_IDLE;
        end else if (status_i.pair) begin
          state_d = ST_EMIT_HELD;
        end else begin
          state_d = ST_EMIT_AVG;
        end
      end
      ST_EMIT_HELD: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_held = 1'b1;
        if (out_ready_i) begin
          state_d = ST_EMIT_AVG;
        end
      end
      ST_EMIT_AVG: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/window_moving_average_top.sv
// Sequence: an item that only fills the window is accepted and added to the sum; any other item
// is accepted, updates the sum, then runs the serial radix-2 divide and the saturation to its first result.
// A new item is taken only once the last one is through, its results included; output stalls hold it.
// Reset: clears sum, count, held average, pointer and sequencer; width returns to 4.
// The 256-entry sample store is not cleared; entries are written before they are read.
// ============================================================================
// window_moving_average_top
// Boxcar moving average over signed samples with a configurable window width.
// ============================================================================
module window_moving_average_top import wma_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  wma_sample_if.sink    in_i,
  wma_average_if.source out_o,
  wma_cfg_if.sink       cfg_i
);

  wma_cmd_t    cmd;
  wma_status_t status;

  assign cfg_i.ready = 1'b1;

  wma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wma_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (in_i.sample),
    .start_i       (in_i.start_of_table),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .average_o     (out_o.average),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

FILE: sim/wma_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wma_checker
// Watches the sample, average and width channels of the moving average
// block. It keeps its own boxcar model, builds the expected averages for
// every accepted sample and compares each accepted average with them.
// ============================================================================
module wma_checker import wma_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  wma_sample_if  smp_i,
  wma_average_if avg_i,
  wma_cfg_if     cfg_i,
  output int     fail_count_o,
  output int     pending_o
);

  localparam int AVG_HI = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int AVG_LO = -AVG_HI - 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   last_of_run;
  } avg_item_t;

  avg_item_t expected_avgs[$];

  // Model of the block's table state.
  logic [WIDTH_BITS-1:0]         width_reg;
  logic signed [SAMPLE_BITS-1:0] tap_store [WINDOW_MAX];
  logic signed [SUM_BITS-1:0]    window_sum;
  logic [WIDTH_BITS-1:0]         fill_count;
  logic [SAMPLE_BITS-1:0]        held_avg;
  logic [PTR_BITS-1:0]           wr_ptr;

  task automatic reset_table();
    window_sum = '0;
    fill_count = '0;
    held_avg   = '0;
    wr_ptr     = '0;
  endtask

  // Truncates toward zero, then clamps to the sample range.
  function automatic logic [SAMPLE_BITS-1:0] window_quotient(
    logic signed [SUM_BITS-1:0] total, int unsigned w);
    int q;
    q = int'(total) / int'(w);
    if (q > AVG_HI) q = AVG_HI;
    else if (q < AVG_LO) q = AVG_LO;
    return SAMPLE_BITS'(q);
  endfunction

  task automatic predict_averages(logic [SAMPLE_BITS-1:0] raw, logic sot);
    logic signed [SAMPLE_BITS-1:0] x;
    int unsigned                   w;
    logic [PTR_BITS-1:0]           old_idx;
    avg_item_t                     item;
    x = raw;
    if (width_reg == '0) w = 1;
    else if (width_reg > WIDTH_TOP) w = WINDOW_MAX;
    else w = width_reg;
    if (sot) reset_table();
    if (fill_count < w) begin
      window_sum = SUM_BITS'(int'(window_sum) + int'(x));
      tap_store[wr_ptr] = x;
      wr_ptr = wr_ptr + PTR_BITS'(1);
      fill_count = fill_count + WIDTH_BITS'(1);
      if (fill_count == w) held_avg = window_quotient(window_sum, w);
    end else begin
      // The sum is never rebuilt, so a width change mid-table carries the old sum.
      old_idx = PTR_BITS'(int'(wr_ptr) + WINDOW_MAX - w);
      window_sum = SUM_BITS'(int'(window_sum) - int'(tap_store[old_idx]) + int'(x));
      tap_store[wr_ptr] = x;
      wr_ptr = wr_ptr + PTR_BITS'(1);
      if (fill_count == w) begin
        item.average     = held_avg;
        item.last_of_run = 1'b0;
        expected_avgs = {expected_avgs, item};
      end
      item.average     = window_quotient(window_sum, w);
      item.last_of_run = 1'b1;
      expected_avgs = {expected_avgs, item};
      fill_count = WIDTH_BITS'(w + 1);
    end
  endtask

  task automatic check_average(logic [SAMPLE_BITS-1:0] average, logic last_of_run);
    avg_item_t exp_item;
    if (expected_avgs.size() == 0) begin
      $error("average item %0d arrived with nothing expected", $signed(average));
      fail_count_o++;
    end else begin
      exp_item = expected_avgs.pop_front();
      if (average !== exp_item.average) begin
        $error("average: expected %0d, got %0d", $signed(exp_item.average),
               $signed(average));
        fail_count_o++;
      end
      if (last_of_run !== exp_item.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", exp_item.last_of_run, last_of_run);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = WIDTH_RESET;
      reset_table();
      expected_avgs.delete();
      pending_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) width_reg = cfg_i.data;
      // Results leave before new expectations join, so an average can never
      // be matched against the sample accepted at the same edge.
      if (avg_i.valid && avg_i.ready) check_average(avg_i.average, avg_i.last_of_run);
      if (smp_i.valid && smp_i.ready) predict_averages(smp_i.sample, smp_i.start_of_table);
      pending_o = expected_avgs.size();
    end
  end

endmodule

FILE: sim/tb_window_moving_average_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_window_moving_average_top
// Drives signed samples and window widths into the moving average block with
// random gaps and output stalls. A directed opening covers the extreme
// samples and the width corner cases, then random tables follow, including
// mid-table width changes and a run that overflows the running sum.
// ============================================================================
module tb_window_moving_average_top;
  import wma_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_TARGET   = 1725;
  localparam int END_LIMIT     = 20000;

  logic clk_i;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   sent_items = 0;
  bit   steady     = 1'b0;
  bit   big_done   = 1'b0;
  bit   wrap_done  = 1'b0;

  wma_sample_if  smp_if ();
  wma_average_if avg_if ();
  wma_cfg_if     cfg_if ();

  window_moving_average_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .out_o  (avg_if),
    .cfg_i  (cfg_if)
  );

  wma_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_i        (smp_if),
    .avg_i        (avg_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly back to back, sometimes a short gap, rarely a long hole.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return AVG_MAX;
    if (r == 1) return AVG_MIN;
    return SAMPLE_BITS'($urandom());
  endfunction

  // Output back-pressure.
  initial begin
    int stall_left;
    stall_left = 0;
    avg_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        avg_if.ready <= 1'b0;
        stall_left--;
      end else begin
        avg_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // All of these are entered and left at a falling edge.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s, logic sot);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_if.valid          <= 1'b1;
    smp_if.sample         <= s;
    smp_if.start_of_table <= sot;
    do @(posedge clk_i); while (!smp_if.ready);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Waits for every expected average, then lets a trailing fill item finish.
  task automatic drain();
    smp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_width(logic [WIDTH_BITS-1:0] w);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Shrinking the width keeps the larger sum, and growing it again only adds,
  // so a few rounds of extreme samples push the sum past its range.
  task automatic build_sum_wrap();
    logic [SAMPLE_BITS-1:0] v;
    v = $urandom_range(0, 1) ? AVG_MAX : AVG_MIN;
    write_width(WIDTH_BITS'(100));
    send_sample(v, 1'b1);
    repeat (100) send_sample(v, 1'b0);
    repeat (2) begin
      write_width(WIDTH_MIN);
      send_sample(v, 1'b0);
      write_width(WIDTH_BITS'(100));
      repeat (99) send_sample(v, 1'b0);
    end
    repeat (10) send_sample(rand_sample(), 1'b0);
    wrap_done = 1'b1;
  endtask

  task automatic run_random_phase();
    int                    kind;
    int                    n;
    logic [WIDTH_BITS-1:0] w;
    bit                    fresh;
    kind = $urandom_range(0, 99);
    if (kind >= 94 && !big_done) begin
      w = $urandom_range(0, 1) ? WIDTH_TOP : WIDTH_BITS'($urandom_range(257, 511));
      n = WINDOW_MAX + $urandom_range(5, 20);
      big_done = 1'b1;
    end else if (kind >= 70) begin
      w = WIDTH_BITS'($urandom_range(17, 64));
      n = w + $urandom_range(5, 30);
    end else begin
      w = ($urandom_range(0, 9) == 0) ? WIDTH_BITS'($urandom_range(0, 16))
                                      : WIDTH_BITS'($urandom_range(1, 8));
      n = $urandom_range(10, 40);
    end
    write_width(w);
    steady = ($urandom_range(0, 4) == 0);
    // Without a start flag the new width takes over in the middle of a table.
    fresh = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      send_sample(rand_sample(), (i == 0 && fresh) || $urandom_range(0, 49) == 0);
    end
    steady = 1'b0;
  endtask

  initial begin
    int waited;
    smp_if.valid          = 1'b0;
    smp_if.sample         = '0;
    smp_if.start_of_table = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.data           = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset width, no start flag: the reset state opens the first table.
    repeat (4) send_sample(AVG_MAX, 1'b0);
    send_sample(AVG_MIN, 1'b0);
    send_sample(AVG_MIN, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);

    // Width above the store size saturates.
    write_width('1);
    send_sample('1, 1'b1);
    send_sample(SAMPLE_BITS'(1), 1'b0);

    // Width zero behaves as one.
    write_width('0);
    send_sample(AVG_MAX, 1'b0);
    send_sample(AVG_MIN, 1'b0);
    send_sample(SAMPLE_BITS'(1), 1'b0);

    // A full window of maximum samples, then a shrink to one: the stale sum
    // overflows the average.
    write_width(WIDTH_BITS'(8));
    send_sample(AVG_MAX, 1'b1);
    repeat (8) send_sample(AVG_MAX, 1'b0);
    write_width(WIDTH_MIN);
    send_sample(AVG_MAX, 1'b0);
    send_sample(AVG_MIN, 1'b0);
    send_sample(AVG_MIN, 1'b1);
    send_sample(AVG_MIN, 1'b0);

    while (sent_items < ITEM_TARGET) begin
      if (!wrap_done && sent_items > 600) build_sum_wrap();
      else run_random_phase();
    end

    smp_if.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < END_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pending != 0) $error("%0d expected averages never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/wma_pkg.sv
src/wma_if.sv
src/wma_ram.sv
src/wma_datapath.sv
src/wma_ctrl.sv
src/window_moving_average_top.sv
sim/wma_checker.sv
sim/tb_window_moving_average_top.sv
